FILE: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned CAPACITY  = 128;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned POS_W     = 7;

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_REPLACED  = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_FULL      = 3'd5,
    STAT_EMPTY     = 3'd6
  } status_e;

  // one table entry, key in the upper bits
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;
  } entry_t;

  // input item, first field lowest
  typedef struct packed {
    logic [PAYLOAD_W-1:0]    payload;
    logic signed [KEY_W-1:0] key;
    cmd_e                    command;
  } req_t;

  // result item, first field lowest
  typedef struct packed {
    logic [CNT_W-1:0]        entry_count;
    logic [PAYLOAD_W-1:0]    payload_out;
    logic signed [KEY_W-1:0] key_out;
    logic [POS_W-1:0]        position;
    status_e                 status;
  } rsp_t;

  localparam int unsigned REQ_W     = $bits(req_t);
  localparam int unsigned RSP_W     = $bits(rsp_t);
  localparam int unsigned S_TDATA_W = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((RSP_W + 7) / 8) * 8;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // memory port request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hw/rtl/sorted_key_table.sv
`timescale 1ns / 1ps

// Sorted key table: up to CAPACITY (128) entries of a signed 32-bit key and a
// 64-bit payload, held in ascending key order in one synchronous RAM. Each
// input item is a command: insert (replaces the payload on an equal key,
// reports full when the table holds CAPACITY entries), remove (returns the
// entry and closes the gap, reports empty or not found) or lookup. Command
// code 3 is taken and dropped without a result. Every other item gives one
// result item with status, position, the removed or found entry and the
// entry count after the command. An item is taken, then the entries are
// scanned from the bottom of the table up to the first key not below the
// new key; then entries are moved (insert moves the entries above the slot
// up, remove moves them down), a new entry is placed and the result is
// handed over. The entry RAM has a single read and a single write port.
// Items run one at a time; the result sits in an output register, so the
// next item is taken while a result still waits downstream. The table is
// empty after reset, with no clearing pass.
module sorted_key_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: command[1:0], key[33:2], payload[97:34], zero fill
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [skt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tdata: status[2:0], position[9:3], key_out[41:10], payload_out[105:42],
  //        entry_count[113:106], zero fill
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [skt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import skt_pkg::*;

  req_t     req;
  rsp_t     rsp;
  logic     rsp_valid;
  logic     rsp_ready;
  ram_req_t ram_req;
  entry_t   ram_rdata;

  logic     out_valid_q, out_valid_d;
  rsp_t     out_data_q, out_data_d;

  assign req = req_t'(s_axis_tdata[REQ_W-1:0]);

  skt_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: free when empty or being drained this cycle.
  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = rsp;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - RSP_W){1'b0}}, out_data_q};

endmodule

FILE: hw/rtl/skt_ram.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read entry store, registered read data.
module skt_ram (
  input  logic              clk_i,
  input  skt_pkg::ram_req_t req_i,
  output skt_pkg::entry_t   rdata_o
);
  import skt_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/skt_ctrl.sv
`timescale 1ns / 1ps

// Command sequencer: scan, shift up / shift down, place entry.
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  skt_pkg::req_t     req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output skt_pkg::rsp_t     rsp_o,
  output skt_pkg::ram_req_t ram_o,
  input  skt_pkg::entry_t   ram_rdata_i
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHUP,
    ST_PUT,
    ST_SHDN,
    ST_DONE
  } state_e;

  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO = CNT_W'(2);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_e                  state_q, state_d;
  cmd_e                    cmd_q, cmd_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PAYLOAD_W-1:0]    pl_q, pl_d;
  logic [CNT_W-1:0]        p_q, p_d;       // scan / target position
  logic [CNT_W-1:0]        a_q, a_d;       // shift write address
  logic [CNT_W-1:0]        count_q, count_d;
  rsp_t                    rsp_q, rsp_d;

  logic [CNT_W-1:0] rd_addr;
  logic [CNT_W-1:0] wr_addr;
  logic             scan_end;
  logic             scan_eq;
  logic [CNT_W-1:0] scan_pos;

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pl_d        = pl_q;
    p_d         = p_q;
    a_d         = a_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    rd_addr     = '0;
    wr_addr     = '0;
    ram_o.we    = 1'b0;
    ram_o.wdata = ram_rdata_i;
    scan_end    = 1'b0;
    scan_eq     = 1'b0;
    scan_pos    = p_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_d = req_i.command;
          key_d = req_i.key;
          pl_d  = req_i.payload;
          p_d   = '0;
          rsp_d = '{entry_count: count_q, payload_out: '0, key_out: '0,
                    position: '0, status: STAT_NOT_FOUND};
          unique case (req_i.command)
            CMD_INSERT: begin
              if (count_q == CAP) begin
                rsp_d.status = STAT_FULL;
                state_d      = ST_DONE;
              end else if (count_q == '0) begin
                state_d = ST_PUT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                rsp_d.status = STAT_EMPTY;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_LOOKUP: begin
              state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
            end
            default: ;  // unused code: dropped, no result
          endcase
        end
      end

      ST_SCAN: begin
        // read data holds entry p_q
        if (ram_rdata_i.key < key_q) begin
          if (p_q + ONE == count_q) begin
            scan_end = 1'b1;
            scan_pos = count_q;
          end else begin
            rd_addr = p_q + ONE;
            p_d     = p_q + ONE;
          end
        end else begin
          scan_end = 1'b1;
          scan_eq  = (ram_rdata_i.key == key_q);
        end

        if (scan_end) begin
          p_d = scan_pos;
          unique case (cmd_q)
            CMD_INSERT: begin
              if (scan_eq) begin
                ram_o.we       = 1'b1;
                wr_addr        = scan_pos;
                ram_o.wdata    = '{key: key_q, payload: pl_q};
                rsp_d.status   = STAT_REPLACED;
                rsp_d.position = POS_W'(scan_pos);
                state_d        = ST_DONE;
              end else if (scan_pos == count_q) begin
                state_d = ST_PUT;
              end else begin
                rd_addr = count_q - ONE;
                a_d     = count_q;
                state_d = ST_SHUP;
              end
            end
            CMD_REMOVE: begin
              if (scan_eq) begin
                rsp_d.status      = STAT_REMOVED;
                rsp_d.position    = POS_W'(scan_pos);
                rsp_d.key_out     = ram_rdata_i.key;
                rsp_d.payload_out = ram_rdata_i.payload;
                rsp_d.entry_count = count_q - ONE;
                if (scan_pos + ONE == count_q) begin
                  count_d = count_q - ONE;
                  state_d = ST_DONE;
                end else begin
                  rd_addr = scan_pos + ONE;
                  a_d     = scan_pos;
                  state_d = ST_SHDN;
                end
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              if (scan_eq) begin
                rsp_d.status      = STAT_FOUND;
                rsp_d.position    = POS_W'(scan_pos);
                rsp_d.key_out     = ram_rdata_i.key;
                rsp_d.payload_out = ram_rdata_i.payload;
              end
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SHUP: begin
        // read data holds entry a_q-1; move it to a_q
        ram_o.we = 1'b1;
        wr_addr  = a_q;
        if (a_q - ONE == p_q) begin
          state_d = ST_PUT;
        end else begin
          rd_addr = a_q - TWO;
          a_d     = a_q - ONE;
        end
      end

      ST_PUT: begin
        ram_o.we          = 1'b1;
        wr_addr           = p_q;
        ram_o.wdata       = '{key: key_q, payload: pl_q};
        count_d           = count_q + ONE;
        rsp_d.status      = STAT_INSERTED;
        rsp_d.position    = POS_W'(p_q);
        rsp_d.entry_count = count_q + ONE;
        state_d           = ST_DONE;
      end

      ST_SHDN: begin
        // read data holds entry a_q+1; move it to a_q
        ram_o.we = 1'b1;
        wr_addr  = a_q;
        if (a_q + TWO == count_q) begin
          count_d = count_q - ONE;
          state_d = ST_DONE;
        end else begin
          rd_addr = a_q + TWO;
          a_d     = a_q + ONE;
        end
      end

      ST_DONE: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    ram_o.raddr = rd_addr[ADDR_W-1:0];
    ram_o.waddr = wr_addr[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_INSERT;
      key_q   <= '0;
      pl_q    <= '0;
      p_q     <= '0;
      a_q     <= '0;
      count_q <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      key_q   <= key_d;
      pl_q    <= pl_d;
      p_q     <= p_d;
      a_q     <= a_d;
      count_q <= count_d;
      rsp_q   <= rsp_d;
    end
  end

endmodule

FILE: hw/rtl/skt_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the sorted key table.
module skt_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [skt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import skt_pkg::*;

  rsp_t obs;
  assign obs = rsp_t'(m_axis_tdata[RSP_W-1:0]);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> obs.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && obs.status == STAT_FULL
      |-> obs.entry_count == CNT_W'(CAPACITY) && obs.position == '0)
    else $error("full reported with room left");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && obs.status == STAT_EMPTY |-> obs.entry_count == '0)
    else $error("empty reported with entries held");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && obs.status == STAT_NOT_FOUND
      |-> obs.position == '0 && obs.key_out == '0 && obs.payload_out == '0)
    else $error("not found result carries entry data");

endmodule

bind sorted_key_table skt_port_checker u_skt_checker (.*);

FILE: tb/skt_checker.sv
`timescale 1ns / 1ps

module skt_checker import skt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: command[1:0], key[33:2], payload[97:34], zero fill
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tdata: status[2:0], position[9:3], key_out[41:10], payload_out[105:42],
  //        entry_count[113:106], zero fill
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int unsigned          err_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned MAX_PRINTS = 40;

  // shadow of the table contents
  logic signed [KEY_W-1:0] table_key     [CAPACITY];
  logic [PAYLOAD_W-1:0]    table_payload [CAPACITY];
  int unsigned             table_fill;

  rsp_t expected_rsp_q [$];

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    table_fill  = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    if (err_count_o < MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got_v, want_v);
    err_count_o++;
  endtask

  // first slot whose key is not below k
  function automatic int unsigned find_slot(input logic signed [KEY_W-1:0] k);
    int unsigned p;
    p = 0;
    while (p < table_fill && table_key[p] < k) p++;
    return p;
  endfunction

  // applies one command to the shadow table, returns the result it gives
  function automatic rsp_t apply_table_cmd(input req_t req);
    rsp_t        r;
    int unsigned p;
    logic        hit;
    r.status      = STAT_NOT_FOUND;
    r.position    = '0;
    r.key_out     = '0;
    r.payload_out = '0;
    p   = find_slot(req.key);
    hit = (p < table_fill) && (table_key[p] == req.key);
    case (req.command)
      CMD_INSERT: begin
        if (table_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (hit) begin
          table_payload[p] = req.payload;
          r.status   = STAT_REPLACED;
          r.position = POS_W'(p);
        end else begin
          for (int unsigned a = table_fill; a > p; a--) begin
            table_key[a]     = table_key[a-1];
            table_payload[a] = table_payload[a-1];
          end
          table_key[p]     = req.key;
          table_payload[p] = req.payload;
          table_fill++;
          r.status   = STAT_INSERTED;
          r.position = POS_W'(p);
        end
      end
      CMD_REMOVE: begin
        if (table_fill == 0) begin
          r.status = STAT_EMPTY;
        end else if (hit) begin
          r.key_out     = table_key[p];
          r.payload_out = table_payload[p];
          for (int unsigned a = p; a + 1 < table_fill; a++) begin
            table_key[a]     = table_key[a+1];
            table_payload[a] = table_payload[a+1];
          end
          table_fill--;
          r.status   = STAT_REMOVED;
          r.position = POS_W'(p);
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          r.key_out     = table_key[p];
          r.payload_out = table_payload[p];
          r.status      = STAT_FOUND;
          r.position    = POS_W'(p);
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(table_fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t got;
    rsp_t want;
    req_t req;
    if (!rst_ni) begin
      table_fill = 0;
      expected_rsp_q.delete();
      pending_o = 0;
    end else begin
      // results first: one accepted now belongs to an older item
      if (m_axis_tvalid && m_axis_tready) begin
        got = rsp_t'(m_axis_tdata[RSP_W-1:0]);
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(got.status), '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.position != want.position)
            report_mismatch("position", 64'(got.position), 64'(want.position));
          if (got.key_out != want.key_out)
            report_mismatch("key_out", 64'(unsigned'(got.key_out)),
                            64'(unsigned'(want.key_out)));
          if (got.payload_out != want.payload_out)
            report_mismatch("payload_out", got.payload_out, want.payload_out);
          if (got.entry_count != want.entry_count)
            report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req = req_t'(s_axis_tdata[REQ_W-1:0]);
        // code 3 is dropped by the block
        if (req.command == CMD_INSERT || req.command == CMD_REMOVE ||
            req.command == CMD_LOOKUP)
          expected_rsp_q.push_back(apply_table_cmd(req));
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Top of the sorted key table bench: clock, reset, stimulus, output stall
// pattern, watchdog and verdict. Checking lives in skt_checker.
module tb;
  import skt_pkg::*;

  localparam int unsigned POOL_SIZE      = 200;
  // covers the longest item plus sender gap and sink stall
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 300;

  // 2-bit code the block takes and drops
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  int unsigned err_count;
  int unsigned pending;

  sorted_key_table i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  skt_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink stall pattern: stretches of always ready, coin flip, or mostly
  // stalled, each stretch of random length.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Watchdog: any accepted item on either side restarts the count.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Keys are drawn mostly from a fixed pool so that inserts collide with
  // stored keys and removes and lookups hit. The pool holds more keys than
  // the table, so the fill phases run into the full case.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      ins_idx   = 0;
  int unsigned      rem_idx   = 0;
  int unsigned      burst_left = 1;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sends one item; holds tvalid through a burst, drops it for a gap after.
  task automatic send_cmd(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [PAYLOAD_W-1:0] payload);
    req_t        req;
    int unsigned gap;
    req.command = cmd_e'(cmd);
    req.key     = key;
    req.payload = payload;
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(req);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic hold_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return rand64();
  endfunction

  // One phase of random traffic with the given command mix (percent);
  // whatever is left over goes to the ignored code.
  task automatic run_phase(input int unsigned n, input int unsigned ins_pct,
                           input int unsigned rem_pct, input int unsigned look_pct);
    int unsigned      r;
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (r < ins_pct) begin
        // mostly fresh keys in pool order, some repeats, some noise
        if (sel < 60) begin
          k = key_pool[ins_idx % POOL_SIZE];
          ins_idx++;
        end else if (sel < 90) begin
          k = key_pool[$urandom_range(0, POOL_SIZE-1)];
        end else begin
          k = $urandom;
        end
        send_cmd(CMD_INSERT, k, pick_payload());
      end else if (r < ins_pct + rem_pct) begin
        // oldest inserted keys in pool order, random pool keys, some noise
        if (sel < 40) begin
          k = key_pool[rem_idx % POOL_SIZE];
          rem_idx++;
        end else if (sel < 90) begin
          k = key_pool[$urandom_range(0, POOL_SIZE-1)];
        end else begin
          k = $urandom;
        end
        send_cmd(CMD_REMOVE, k, rand64());
      end else if (r < ins_pct + rem_pct + look_pct) begin
        k = (sel < 85) ? key_pool[$urandom_range(0, POOL_SIZE-1)] : $urandom;
        send_cmd(CMD_LOOKUP, k, rand64());
      end else begin
        send_cmd(CMD_IGNORED, $urandom, rand64());
      end
    end
  endtask

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  initial begin
    // pool: extremes and neighbors first, random keys after
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h8000_0001;
    key_pool[5] = 32'h7FFF_FFFE;
    key_pool[6] = 32'h0000_0001;
    for (int unsigned i = 7; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table cases, extremes of key and payload, replace,
    // remove at bottom and top, not-found paths, ignored code.
    send_cmd(CMD_REMOVE, 32'h0, 64'h0);                    // remove on empty
    send_cmd(CMD_LOOKUP, KEY_MIN, 64'h0);                  // lookup on empty
    send_cmd(CMD_INSERT, KEY_MAX, '1);
    send_cmd(CMD_INSERT, KEY_MIN, '0);
    send_cmd(CMD_INSERT, 32'h0, 64'h5555_5555_5555_5555);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(CMD_INSERT, 32'h1, 64'h0123_4567_89AB_CDEF);
    send_cmd(CMD_INSERT, KEY_MAX, 64'hFEDC_BA98_7654_3210); // equal key: replace
    send_cmd(CMD_LOOKUP, KEY_MIN, 64'h0);
    send_cmd(CMD_LOOKUP, KEY_MAX, 64'h0);
    send_cmd(CMD_LOOKUP, 32'h2, 64'h0);                    // absent
    send_cmd(CMD_REMOVE, 32'h2, 64'h0);                    // absent
    send_cmd(CMD_REMOVE, KEY_MIN, 64'h0);                  // bottom entry
    send_cmd(CMD_REMOVE, KEY_MAX, 64'h0);                  // top entry
    send_cmd(CMD_IGNORED, 32'h1234_5678, rand64());
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 64'h0);            // bottom entry
    send_cmd(CMD_LOOKUP, 32'h0, 64'h0);
    send_cmd(CMD_REMOVE, 32'h0, 64'h0);
    send_cmd(CMD_REMOVE, 32'h1, 64'h0);                    // table now empty
    send_cmd(CMD_REMOVE, 32'h1, 64'h0);                    // empty again
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0);
    send_cmd(CMD_IGNORED, '1, '1);
    send_cmd(CMD_INSERT, 32'h8000_0001, rand64());
    send_cmd(CMD_INSERT, 32'h7FFF_FFFE, rand64());

    // Random: fill to full, churn, drain to empty, twice over.
    run_phase(180, 90, 3, 5);
    run_phase(150, 40, 30, 25);
    hold_for_results();
    run_phase(200, 5, 70, 20);
    run_phase(180, 90, 3, 5);
    run_phase(140, 40, 30, 25);
    hold_for_results();
    run_phase(200, 5, 70, 20);

    // wait for the last results, then idle for DRAIN_CYCLES before the verdict
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_ram.sv
hw/rtl/skt_ctrl.sv
hw/rtl/sorted_key_table.sv
hw/rtl/skt_checker.sv
tb/skt_checker.sv
tb/tb.sv
